// ===== hdl/pfb_segment_deframer_unit_macros.svh =====
// Assertion macros for the segment deframer checker.
// Expect clk and rst_n in the scope that uses them.
`ifndef PFB_SEGMENT_DEFRAMER_UNIT_MACROS_SVH
`define PFB_SEGMENT_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define PFBSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfbsd check failed");

// Next-cycle implication, muted during reset.
`define PFBSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfbsd check failed");

`endif

// ===== hdl/pfbsd_pkg.sv =====
// Shared types and constants for the segment deframer.
// No dependencies; used by every module of the block.
package pfbsd_pkg;

    localparam logic [7:0] SEG_MARK      = 8'h80;
    localparam logic [7:0] KIND_ASCII    = 8'd1;
    localparam logic [7:0] KIND_BINARY   = 8'd2;
    localparam logic [2:0] HDR_POS_MARK  = 3'd0;
    localparam logic [2:0] HDR_POS_KIND  = 3'd1;
    localparam logic [2:0] HDR_POS_LEN0  = 3'd2;
    localparam logic [2:0] HDR_POS_LEN1  = 3'd3;
    localparam logic [2:0] HDR_POS_LEN2  = 3'd4;
    localparam logic [2:0] HDR_POS_LEN3  = 3'd5;
    localparam int         OUT_TDATA_W   = 48;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_PLAIN,
        PH_HEADER,
        PH_PAYLOAD,
        PH_STOPPED
    } phase_t;

    typedef enum logic [1:0] {
        ST_PLAIN,
        ST_OK,
        ST_DROP_TAIL,
        ST_USE_RAW
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        keep;
        logic        final_mark;
        status_t     file_status;
        logic [31:0] tail_to_drop;
    } result_t;

endpackage

// ===== hdl/pfbsd_in_stage.sv =====
// Input register of the segment deframer: captures one byte beat per cycle while the held beat moves on.
// Depends on pfbsd_pkg.
module pfbsd_in_stage
    import pfbsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     [7:0] s_tdata,   // [7:0] data_byte
    input  logic     s_tlast,
    input  logic     advance,
    output logic     beat_valid,
    output in_beat_t beat
);

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    // Free when empty or when the held beat moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            beat_reg.data_byte <= s_tdata;
            beat_reg.is_final  <= s_tlast;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ===== hdl/pfbsd_parser.sv =====
// Segment header parser: holds the file state and works out keep and status.
// Depends on pfbsd_pkg.
module pfbsd_parser
    import pfbsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_beat_t beat,
    output result_t  result
);

    phase_t      phase_reg,   phase_next;
    logic [2:0]  pos_reg,     pos_next;
    logic [7:0]  kind_reg,    kind_next;
    logic [31:0] len_reg,     len_next;
    logic [31:0] left_reg,    left_next;
    logic        keepseg_reg, keepseg_next;
    logic        seen_reg,    seen_next;
    logic [31:0] tail_reg,    tail_next;

    phase_t      phase_eff;
    logic [31:0] len_full;
    logic [31:0] lane;
    logic        b_is_mark;

    assign b_is_mark = (beat.data_byte == SEG_MARK);

    // Resolve the first byte of a file into plain or segmented
    always_comb
    begin
        phase_eff = phase_reg;
        if (phase_reg == PH_FIRST)
        begin
            phase_eff = (b_is_mark && !beat.is_final) ? PH_HEADER : PH_PLAIN;
        end
    end

    always_comb
    begin
        case (pos_reg)
            HDR_POS_LEN0: lane = {24'd0, beat.data_byte};
            HDR_POS_LEN1: lane = {16'd0, beat.data_byte, 8'd0};
            HDR_POS_LEN2: lane = {8'd0, beat.data_byte, 16'd0};
            HDR_POS_LEN3: lane = {beat.data_byte, 24'd0};
            default:      lane = 32'd0;
        endcase
    end

    assign len_full = len_reg | lane;

    // Next state, before the end-of-file clear
    always_comb
    begin
        phase_next   = phase_eff;
        pos_next     = pos_reg;
        kind_next    = kind_reg;
        len_next     = len_reg;
        left_next    = left_reg;
        keepseg_next = keepseg_reg;
        seen_next    = seen_reg;
        tail_next    = tail_reg;
        case (phase_eff)
            PH_HEADER:
            begin
                if (pos_reg == HDR_POS_MARK && !b_is_mark)
                begin
                    phase_next = PH_STOPPED;
                end
                else
                begin
                    if (pos_reg == HDR_POS_MARK)
                    begin
                        len_next = 32'd0;
                    end
                    else if (pos_reg == HDR_POS_KIND)
                    begin
                        kind_next = beat.data_byte;
                    end
                    else
                    begin
                        len_next = len_full;
                    end
                    pos_next = pos_reg + 3'd1;
                    if (pos_reg == HDR_POS_LEN3)
                    begin
                        pos_next     = HDR_POS_MARK;
                        left_next    = len_full;
                        keepseg_next = (kind_reg == KIND_ASCII) || (kind_reg == KIND_BINARY);
                        tail_next    = 32'd0;
                        phase_next   = (len_full == 32'd0) ? PH_HEADER : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (keepseg_reg)
                begin
                    tail_next = tail_reg + 32'd1;
                end
                left_next = left_reg - 32'd1;
                if (left_reg == 32'd1)
                begin
                    seen_next  = seen_reg | keepseg_reg;
                    tail_next  = 32'd0;
                    phase_next = PH_HEADER;
                    pos_next   = HDR_POS_MARK;
                end
            end
            default:
            begin
                phase_next = phase_eff;
            end
        endcase
    end

    // Result for this beat
    always_comb
    begin
        result.out_byte     = beat.data_byte;
        result.final_mark   = beat.is_final;
        result.file_status  = ST_PLAIN;
        result.tail_to_drop = 32'd0;
        case (phase_eff)
            PH_PLAIN:   result.keep = 1'b1;
            PH_PAYLOAD: result.keep = keepseg_reg;
            default:    result.keep = 1'b0;
        endcase
        if (beat.is_final)
        begin
            if (phase_next == PH_PLAIN)
            begin
                result.file_status = ST_PLAIN;
            end
            else if (!seen_next)
            begin
                result.file_status = ST_USE_RAW;
            end
            else if (phase_next == PH_PAYLOAD && tail_next != 32'd0)
            begin
                result.file_status  = ST_DROP_TAIL;
                result.tail_to_drop = tail_next;
            end
            else
            begin
                result.file_status = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST;
            pos_reg     <= HDR_POS_MARK;
            kind_reg    <= 8'd0;
            len_reg     <= 32'd0;
            left_reg    <= 32'd0;
            keepseg_reg <= 1'b0;
            seen_reg    <= 1'b0;
            tail_reg    <= 32'd0;
        end
        else if (step)
        begin
            if (beat.is_final)
            begin
                // Start afresh with the next file
                phase_reg   <= PH_FIRST;
                pos_reg     <= HDR_POS_MARK;
                kind_reg    <= 8'd0;
                len_reg     <= 32'd0;
                left_reg    <= 32'd0;
                keepseg_reg <= 1'b0;
                seen_reg    <= 1'b0;
                tail_reg    <= 32'd0;
            end
            else
            begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                kind_reg    <= kind_next;
                len_reg     <= len_next;
                left_reg    <= left_next;
                keepseg_reg <= keepseg_next;
                seen_reg    <= seen_next;
                tail_reg    <= tail_next;
            end
        end
    end

endmodule

// ===== hdl/pfbsd_out_stage.sv =====
// Result register of the segment deframer, driving the master-side stream.
// Depends on pfbsd_pkg.
module pfbsd_out_stage
    import pfbsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_valid,
    input  result_t                res,
    output logic                   advance,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Take a new result when empty or when the held one is taken now
    assign advance    = !valid_reg || m_tready;
    assign valid_next = advance ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.tail_to_drop, res_reg.file_status, res_reg.out_byte};
    assign m_tuser  = res_reg.keep;
    assign m_tlast  = res_reg.final_mark;

endmodule

// ===== hdl/pfb_segment_deframer_unit.sv =====
// Segment deframer for segmented font files. One byte beat in per clock, one result
// beat out per clock; the result for a byte passes the input register, then the result
// register, before it is presented on the master side. Full rate holds as long as the
// sink takes beats. The header parser decides keep and file status for a byte in a
// single pass, so throughput is one byte per clock.
// Status and tail count are valid on the beat flagged by m_tlast.
module pfb_segment_deframer_unit
    import pfbsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // is_final
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [9:8] file_status,
                                              // [41:10] tail_to_drop, [47:42] zero
    output logic                   m_tuser,   // keep
    output logic                   m_tlast    // final_mark
);

    logic     advance;
    logic     beat_valid;
    in_beat_t beat;
    result_t  res;

    pfbsd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    pfbsd_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (beat_valid && advance),
        .beat   (beat),
        .result (res)
    );

    pfbsd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (beat_valid),
        .res       (res),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== hdl/pfbsd_checker.sv =====
// Port-level checks for the segment deframer, bound to the top level.
// Depends on pfbsd_pkg and pfb_segment_deframer_unit_macros.svh.
`include "pfb_segment_deframer_unit_macros.svh"

module pfbsd_checker
    import pfbsd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser,
    input logic                   m_tlast
);

    // Hold a result beat until the sink takes it
    `PFBSD_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    // Status reported on the last beat of a file only
    `PFBSD_ASSERT_NOW(a_status_at_last, m_tvalid && !m_tlast, m_tdata[9:8] == ST_PLAIN)
    // Tail count only with the discard-tail status, and never empty there
    `PFBSD_ASSERT_NOW(a_tail_only_drop, m_tvalid && m_tdata[9:8] != ST_DROP_TAIL,
                      m_tdata[41:10] == 32'd0)
    `PFBSD_ASSERT_NOW(a_tail_nonzero, m_tvalid && m_tdata[9:8] == ST_DROP_TAIL,
                      m_tdata[41:10] != 32'd0)
    // The last beat of a plain file is kept
    `PFBSD_ASSERT_NOW(a_plain_keeps, m_tvalid && m_tlast && m_tdata[9:8] == ST_PLAIN, m_tuser)

endmodule

bind pfb_segment_deframer_unit pfbsd_checker u_pfbsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== verif/tb_pfb_segment_deframer_unit.sv =====
// Self-checking bench for pfb_segment_deframer_unit: a directed table, then random plain,
// segmented, broken and noise files, each result beat checked against a predictor or pin.
// Depends on pfbsd_pkg and the deframer RTL only.
`timescale 1ns / 1ps

module tb_pfb_segment_deframer_unit;
    import pfbsd_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1650;
    localparam int unsigned MAX_WAIT     = 12;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
        logic       pinned;
        result_t    pin;
    } stim_row_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = 8'h00;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // predictor state
    phase_t      pp_phase;
    logic [2:0]  pp_hpos;
    logic [7:0]  pp_kind;
    logic [31:0] pp_len;
    logic [31:0] pp_left;
    logic [31:0] pp_tail;
    logic        pp_keep_seg;
    logic        pp_prog;

    result_t     due_results[$];
    stim_row_t   directed_rows[$];
    logic [7:0]  file_bytes[$];
    int unsigned sent_bytes = 0;
    int unsigned fail_count = 0;
    bit          src_burst  = 1'b0;
    bit          sink_burst = 1'b0;

    pfb_segment_deframer_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void reset_deframer();
        pp_phase    = PH_FIRST;
        pp_hpos     = HDR_POS_MARK;
        pp_kind     = 8'h00;
        pp_len      = 32'd0;
        pp_left     = 32'd0;
        pp_tail     = 32'd0;
        pp_keep_seg = 1'b0;
        pp_prog     = 1'b0;
    endfunction

    function automatic result_t deframe_byte(input logic [7:0] b, input logic fin);
        result_t r;
        logic    k;
        k = 1'b0;
        if (pp_phase == PH_FIRST)
        begin
            pp_phase = (b == SEG_MARK && !fin) ? PH_HEADER : PH_PLAIN;
            pp_hpos  = HDR_POS_MARK;
        end
        case (pp_phase)
            PH_PLAIN:
                k = 1'b1;
            PH_HEADER:
            begin
                if (pp_hpos == HDR_POS_MARK && b != SEG_MARK)
                    pp_phase = PH_STOPPED;
                else
                begin
                    case (pp_hpos)
                        HDR_POS_MARK: pp_len = 32'd0;
                        HDR_POS_KIND: pp_kind = b;
                        HDR_POS_LEN0: pp_len[7:0] = b;
                        HDR_POS_LEN1: pp_len[15:8] = b;
                        HDR_POS_LEN2: pp_len[23:16] = b;
                        default:      pp_len[31:24] = b;
                    endcase
                    if (pp_hpos == HDR_POS_LEN3)
                    begin
                        pp_hpos     = HDR_POS_MARK;
                        pp_left     = pp_len;
                        pp_keep_seg = (pp_kind == KIND_ASCII || pp_kind == KIND_BINARY);
                        pp_tail     = 32'd0;
                        pp_phase    = (pp_len == 32'd0) ? PH_HEADER : PH_PAYLOAD;
                    end
                    else
                        pp_hpos = pp_hpos + 3'd1;
                end
            end
            PH_PAYLOAD:
            begin
                k = pp_keep_seg;
                if (k)
                    pp_tail = pp_tail + 32'd1;
                pp_left = pp_left - 32'd1;
                // segment complete: back to header parsing
                if (pp_left == 32'd0)
                begin
                    if (k)
                        pp_prog = 1'b1;
                    pp_tail  = 32'd0;
                    pp_phase = PH_HEADER;
                    pp_hpos  = HDR_POS_MARK;
                end
            end
            default:
                k = 1'b0;
        endcase

        r              = '0;
        r.out_byte     = b;
        r.keep         = k;
        r.final_mark   = fin;
        r.file_status  = ST_PLAIN;
        r.tail_to_drop = 32'd0;
        if (fin)
        begin
            if (pp_phase == PH_PLAIN)
                r.file_status = ST_PLAIN;
            else if (!pp_prog)
                r.file_status = ST_USE_RAW;
            else if (pp_phase == PH_PAYLOAD && pp_tail != 32'd0)
            begin
                r.file_status  = ST_DROP_TAIL;
                r.tail_to_drop = pp_tail;
            end
            else
                r.file_status = ST_OK;
            reset_deframer();
        end
        return r;
    endfunction

    function automatic stim_row_t free_row(input logic [7:0] b, input logic fin);
        stim_row_t t;
        t           = '0;
        t.data_byte = b;
        t.is_final  = fin;
        return t;
    endfunction

    function automatic stim_row_t pinned_row(input logic [7:0] b, input logic keep,
                                             input status_t st, input logic [31:0] drop);
        stim_row_t t;
        t                  = '0;
        t.data_byte        = b;
        t.is_final         = 1'b1;
        t.pinned           = 1'b1;
        t.pin.out_byte     = b;
        t.pin.keep         = keep;
        t.pin.final_mark   = 1'b1;
        t.pin.file_status  = st;
        t.pin.tail_to_drop = drop;
        return t;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int unsigned gap;
        gap = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
        // lower valid only when a gap follows, so it never drops and rises in one step
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        sent_bytes++;
    endtask

    task automatic build_file();
        int unsigned mode;
        int unsigned nseg;
        int unsigned n;
        int unsigned cut;
        logic [7:0]  kind;
        logic [7:0]  junk;
        logic [31:0] seg_len;
        bit          huge;
        file_bytes.delete();
        huge = 1'b0;
        mode = $urandom_range(0, 99);
        if (mode < 12)
        begin
            n = $urandom_range(1, 16);
            repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (mode < 24)
        begin
            // noise behind a marker byte
            file_bytes.push_back(SEG_MARK);
            n = $urandom_range(0, 16);
            repeat (n)
                file_bytes.push_back(($urandom_range(0, 9) < 3) ? SEG_MARK
                                                                 : 8'($urandom_range(0, 255)));
        end
        else
        begin
            nseg = $urandom_range(1, 4);
            for (int s = 0; s < nseg && !huge; s++)
            begin
                n = $urandom_range(0, 9);
                kind = (n < 4) ? KIND_ASCII : (n < 8) ? KIND_BINARY
                                                      : 8'($urandom_range(0, 255));
                n = $urandom_range(0, 99);
                if (n < 10)
                    seg_len = 32'd0;
                else if (n < 85)
                    seg_len = $urandom_range(1, 24);
                else if (n < 95)
                    seg_len = $urandom_range(25, 80);
                else
                begin
                    huge    = 1'b1;
                    seg_len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                          : ($urandom() | 32'h0000_0100);
                end
                file_bytes.push_back(SEG_MARK);
                file_bytes.push_back(kind);
                file_bytes.push_back(seg_len[7:0]);
                file_bytes.push_back(seg_len[15:8]);
                file_bytes.push_back(seg_len[23:16]);
                file_bytes.push_back(seg_len[31:24]);
                // a huge segment always ends the file inside its payload
                n = huge ? $urandom_range(1, 40) : seg_len;
                repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            if (!huge && $urandom_range(0, 4) == 0)
            begin
                junk = 8'($urandom_range(0, 254));
                if (junk >= SEG_MARK)
                    junk = junk + 8'd1;
                file_bytes.push_back(junk);
                n = $urandom_range(0, 6);
                repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            if (file_bytes.size() > 1 && $urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut)
                    file_bytes.delete(file_bytes.size() - 1);
            end
        end
    endtask

    // sink side: random hold before each beat, or whole files taken at full rate in a sink burst
    initial
    begin
        int unsigned hold;
        forever
        begin
            hold = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got              = '0;
            got.out_byte     = m_tdata[7:0];
            got.keep         = m_tuser;
            got.final_mark   = m_tlast;
            got.file_status  = status_t'(m_tdata[9:8]);
            got.tail_to_drop = m_tdata[41:10];
            if (due_results.size() == 0)
            begin
                $error("unexpected result beat: out_byte %h", got.out_byte);
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (got.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                    fail_count++;
                end
                if (got.keep !== want.keep)
                begin
                    $error("keep: expected %b, got %b", want.keep, got.keep);
                    fail_count++;
                end
                if (got.final_mark !== want.final_mark)
                begin
                    $error("final_mark: expected %b, got %b", want.final_mark,
                           got.final_mark);
                    fail_count++;
                end
                if (got.file_status !== want.file_status)
                begin
                    $error("file_status: expected %0d, got %0d", want.file_status,
                           got.file_status);
                    fail_count++;
                end
                if (got.tail_to_drop !== want.tail_to_drop)
                begin
                    $error("tail_to_drop: expected %0d, got %0d", want.tail_to_drop,
                           got.tail_to_drop);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        result_t predicted;
        reset_deframer();

        // one-byte file holding only the marker: plain
        directed_rows.push_back(pinned_row(SEG_MARK, 1'b1, ST_PLAIN, 32'd0));
        // empty segment of a dropped kind, bad marker, rest dropped: no program
        directed_rows.push_back(free_row(SEG_MARK, 1'b0));
        directed_rows.push_back(free_row(8'h00, 1'b0));
        directed_rows.push_back(free_row(8'h00, 1'b0));
        directed_rows.push_back(free_row(8'h00, 1'b0));
        directed_rows.push_back(free_row(8'h00, 1'b0));
        directed_rows.push_back(free_row(8'h00, 1'b0));
        directed_rows.push_back(free_row(8'h7F, 1'b0));
        directed_rows.push_back(pinned_row(8'h00, 1'b0, ST_USE_RAW, 32'd0));
        // header cut short at the end
        directed_rows.push_back(free_row(SEG_MARK, 1'b0));
        directed_rows.push_back(pinned_row(8'h03, 1'b0, ST_USE_RAW, 32'd0));
        // one complete kept segment, then a maximum-length one cut after one byte
        directed_rows.push_back(free_row(SEG_MARK, 1'b0));
        directed_rows.push_back(free_row(KIND_ASCII, 1'b0));
        directed_rows.push_back(free_row(8'h01, 1'b0));
        directed_rows.push_back(free_row(8'h00, 1'b0));
        directed_rows.push_back(free_row(8'h00, 1'b0));
        directed_rows.push_back(free_row(8'h00, 1'b0));
        directed_rows.push_back(free_row(8'h5A, 1'b0));
        directed_rows.push_back(free_row(SEG_MARK, 1'b0));
        directed_rows.push_back(free_row(KIND_BINARY, 1'b0));
        directed_rows.push_back(free_row(8'hFF, 1'b0));
        directed_rows.push_back(free_row(8'hFF, 1'b0));
        directed_rows.push_back(free_row(8'hFF, 1'b0));
        directed_rows.push_back(free_row(8'hFF, 1'b0));
        directed_rows.push_back(pinned_row(8'h12, 1'b1, ST_DROP_TAIL, 32'd1));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].data_byte, directed_rows[i].is_final);
            predicted = deframe_byte(directed_rows[i].data_byte, directed_rows[i].is_final);
            due_results.push_back(directed_rows[i].pinned ? directed_rows[i].pin : predicted);
        end

        while (sent_bytes < RANDOM_BYTES)
        begin
            build_file();
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            foreach (file_bytes[i])
            begin
                send_byte(file_bytes[i], i == file_bytes.size() - 1);
                due_results.push_back(deframe_byte(file_bytes[i],
                                                   i == file_bytes.size() - 1));
            end
        end
        s_tvalid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
